FILE: sv/length_prefix_deframer_core_defines.svh
// Assertion macros for the length-prefix deframer checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define LPD_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPD_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/lpd_pkg.sv
// Shared types and constants for the length-prefix deframer.
// No dependencies.
`default_nettype none
package lpd_pkg;

    localparam int CONNECTIONS_DEF = 256;
    localparam int CONN_W          = 8;
    localparam int MAX_DEPTH       = 1 << CONN_W;

    localparam logic [1:0] PH_HIGH    = 2'd0;
    localparam logic [1:0] PH_LOW     = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    typedef struct packed {
        logic [1:0]  phase;
        logic [7:0]  hdr_high;
        logic [15:0] remaining;
        logic        started;
    } t_ctx;

    typedef struct packed {
        logic [7:0] conn_id;
        logic [7:0] payload_byte;
        logic       first;
        logic       last;
        logic       empty;
    } t_res;

    typedef struct packed {
        logic wr_en;
        t_ctx ctx_new;
        logic res_vld;
        t_res res;
    } t_step;

endpackage
`default_nettype wire

FILE: sv/lpd_ctx_store.sv
// Per-connection context memory: one write and one registered read per cycle.
// Valid bits make never-written entries read back in the header-high phase.
// Depends on lpd_pkg.
`default_nettype none
module lpd_ctx_store #(
    parameter int DEPTH = lpd_pkg::MAX_DEPTH,
    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_re,
    input  wire logic [IW-1:0] i_raddr,
    input  wire logic          i_we,
    input  wire logic [IW-1:0] i_waddr,
    input  wire lpd_pkg::t_ctx i_wdata,
    output lpd_pkg::t_ctx      o_rdata
);

    lpd_pkg::t_ctx     r_mem [DEPTH];
    logic [DEPTH-1:0]  r_vld;
    lpd_pkg::t_ctx     r_rd;
    logic              r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            if (i_re) begin
                r_rd_vld <= r_vld[i_raddr];
            end
        end
    end

    always_comb begin
        o_rdata = r_rd;
        if (!r_rd_vld) begin
            o_rdata.phase = lpd_pkg::PH_HIGH;
        end
    end

endmodule
`default_nettype wire

FILE: sv/lpd_parse.sv
// Header/payload parse step: next context and optional result for one transfer.
// Depends on lpd_pkg.
`default_nettype none
module lpd_parse (
    input  wire logic          i_in_range,
    input  wire logic          i_op,
    input  wire logic [7:0]    i_conn_id,
    input  wire logic [7:0]    i_data_byte,
    input  wire lpd_pkg::t_ctx i_ctx,
    output lpd_pkg::t_step     o_step
);

    logic [15:0] len;
    logic [15:0] rem_dec;
    logic        last;

    always_comb begin
        len     = {i_ctx.hdr_high, i_data_byte};
        rem_dec = (i_ctx.remaining != 16'd0) ? i_ctx.remaining - 16'd1 : 16'd0;
        last    = (rem_dec == 16'd0);

        o_step                      = '0;
        o_step.ctx_new              = i_ctx;
        o_step.res.conn_id          = i_conn_id;
        o_step.wr_en                = i_in_range;

        if (i_op == lpd_pkg::OP_CLOSE) begin
            o_step.ctx_new.phase = lpd_pkg::PH_HIGH;
        end else begin
            unique case (i_ctx.phase)
                lpd_pkg::PH_LOW: begin
                    if (len == 16'd0) begin
                        o_step.ctx_new.phase = lpd_pkg::PH_HIGH;
                        o_step.res_vld       = i_in_range;
                        o_step.res.first     = 1'b1;
                        o_step.res.last      = 1'b1;
                        o_step.res.empty     = 1'b1;
                    end else begin
                        o_step.ctx_new.phase     = lpd_pkg::PH_PAYLOAD;
                        o_step.ctx_new.remaining = len;
                        o_step.ctx_new.started   = 1'b0;
                    end
                end
                lpd_pkg::PH_PAYLOAD: begin
                    o_step.ctx_new.remaining = rem_dec;
                    o_step.ctx_new.started   = 1'b1;
                    o_step.ctx_new.phase     = last ? lpd_pkg::PH_HIGH : lpd_pkg::PH_PAYLOAD;
                    o_step.res_vld           = i_in_range;
                    o_step.res.payload_byte  = i_data_byte;
                    o_step.res.first         = !i_ctx.started;
                    o_step.res.last          = last;
                end
                default: begin
                    // header high byte; unused phase code behaves the same
                    o_step.ctx_new.hdr_high = i_data_byte;
                    o_step.ctx_new.phase    = lpd_pkg::PH_LOW;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/length_prefix_deframer_core.sv
// Top level of the length-prefix deframer: input stage, context forwarding, output register.
// Depends on lpd_pkg, lpd_ctx_store and lpd_parse.
//
// Takes one byte or close event per clock while o_stall is low, tagged with a
// connection number, and emits payload bytes with first/last marks (an empty
// packet gives one result flagged empty). Throughput is one transfer per cycle
// while not stalled; a result passes through the input stage and output
// registers. Each transfer does a read-modify-write of its connection context
// in a single-port-read, single-port-write memory; back-to-back transfers on
// the same connection are served from a one-entry forwarding register. Per-entry
// valid bits give reset contexts at once, so no clearing pass runs after reset.
// Connection numbers not below CONNECTIONS are accepted and dropped.
`default_nettype none
module length_prefix_deframer_core #(
    parameter int CONNECTIONS = lpd_pkg::CONNECTIONS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic       i_op,
    input  wire logic [7:0] i_conn_id,
    input  wire logic [7:0] i_data_byte,
    output logic            o_valid,
    input  wire logic       i_stall,
    output logic [7:0]      o_out_conn_id,
    output logic [7:0]      o_payload_byte,
    output logic            o_first_of_packet,
    output logic            o_last_of_packet,
    output logic            o_empty_packet
);

    localparam int DEPTH = (CONNECTIONS < lpd_pkg::MAX_DEPTH) ? CONNECTIONS
                                                               : lpd_pkg::MAX_DEPTH;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [lpd_pkg::CONN_W:0] LIMIT = (lpd_pkg::CONN_W + 1)'(DEPTH);

    logic           r_s1_vld;
    logic           r_op;
    logic [7:0]     r_conn;
    logic [7:0]     r_data;
    logic           r_byp;
    lpd_pkg::t_ctx  r_byp_ctx;
    logic           r_o_vld;
    lpd_pkg::t_res  r_o_res;

    lpd_pkg::t_ctx  rd_ctx;
    lpd_pkg::t_ctx  cur_ctx;
    lpd_pkg::t_step step;
    logic           in_range;
    logic           out_free;
    logic           s1_adv;
    logic           acc;
    logic           we;

    assign in_range = ({1'b0, r_conn} < LIMIT);
    assign cur_ctx  = r_byp ? r_byp_ctx : rd_ctx;
    assign out_free = !r_o_vld || !i_stall;
    assign s1_adv   = r_s1_vld && (!step.res_vld || out_free);
    assign o_stall  = r_s1_vld && !s1_adv;
    assign acc      = i_valid && !o_stall;
    assign we       = s1_adv && step.wr_en;

    lpd_ctx_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_re    (acc),
        .i_raddr (i_conn_id[IW-1:0]),
        .i_we    (we),
        .i_waddr (r_conn[IW-1:0]),
        .i_wdata (step.ctx_new),
        .o_rdata (rd_ctx)
    );

    lpd_parse u_parse (
        .i_in_range  (in_range),
        .i_op        (r_op),
        .i_conn_id   (r_conn),
        .i_data_byte (r_data),
        .i_ctx       (cur_ctx),
        .o_step      (step)
    );

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_op      <= i_op;
            r_conn    <= i_conn_id;
            r_data    <= i_data_byte;
            r_byp_ctx <= step.ctx_new;
        end
        if (out_free && s1_adv && step.res_vld) begin
            r_o_res <= step.res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_byp    <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (acc) begin
                r_s1_vld <= 1'b1;
                r_byp    <= we && (i_conn_id == r_conn);
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (out_free) begin
                r_o_vld <= s1_adv && step.res_vld;
            end
        end
    end

    assign o_valid           = r_o_vld;
    assign o_out_conn_id     = r_o_res.conn_id;
    assign o_payload_byte    = r_o_res.payload_byte;
    assign o_first_of_packet = r_o_res.first;
    assign o_last_of_packet  = r_o_res.last;
    assign o_empty_packet    = r_o_res.empty;

endmodule
`default_nettype wire

FILE: sv/lpd_checker.sv
// Port-level checks for the length-prefix deframer, bound to the top level.
// Depends on length_prefix_deframer_core_defines.svh.
`default_nettype none
`include "length_prefix_deframer_core_defines.svh"
module lpd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_conn_id,
    input wire logic [7:0] o_payload_byte,
    input wire logic       o_first_of_packet,
    input wire logic       o_last_of_packet,
    input wire logic       o_empty_packet
);

    `LPD_ASSERT_NXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_out_conn_id) && $stable(o_payload_byte),
        "stalled result changed")
    `LPD_ASSERT_IMP(a_empty_form, o_valid && o_empty_packet,
        o_first_of_packet && o_last_of_packet && (o_payload_byte == 8'd0),
        "malformed empty packet result")
    `LPD_ASSERT_IMP(a_no_stall_when_out_free, !o_valid, !o_stall,
        "input stalled with output register empty")
    `LPD_ASSERT_NXT(a_first_after_last, o_valid && !i_stall && o_last_of_packet,
        !(o_valid && (o_out_conn_id == $past(o_out_conn_id))) || o_first_of_packet,
        "packet after last did not start with first")

endmodule

bind length_prefix_deframer_core lpd_checker u_lpd_checker (.*);
`default_nettype wire
